>>> rtl/core/fpa_pkg.sv
// shared types and codes for the fixed-point alu
package fpa_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_ITOF = 3'd4,
    OP_FTOI = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               overflow;
    logic               divide_by_zero;
  } fpa_out_t;

  // state handed from one divider cell to the next
  typedef struct packed {
    logic        vld;
    logic [2:0]  opcode;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [31:0] dvs;
    logic        neg;
    logic [31:0] res;
    logic        ovf;
    logic        dz;
  } fpa_cell_t;

endpackage

>>> rtl/core/fpa_cell.sv
// one restoring division step cell; other ops pass through unchanged
module fpa_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpa_pkg::fpa_cell_t cell_i,
  output fpa_pkg::fpa_cell_t cell_o
);
  import fpa_pkg::*;

  fpa_cell_t cell_d;
  fpa_cell_t cell_q;
  logic      vld_q;
  logic [63:0] part;
  logic [64:0] trial;

  // try subtracting divisor at this bit position
  always_comb begin
    cell_d = cell_i;
    part   = cell_i.rem >> BitIdx;
    trial  = {1'b0, part} - {33'd0, cell_i.dvs};
    if (cell_i.opcode == OP_DIV && !trial[64]) begin
      cell_d.rem         = cell_i.rem - ({32'd0, cell_i.dvs} << BitIdx);
      cell_d.quo[BitIdx] = 1'b1;
    end
  end

  // valid bit, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  // hand registered state to the next cell
  always_comb begin
    cell_o     = cell_q;
    cell_o.vld = vld_q;
  end
endmodule

>>> rtl/core/fixed_point_alu.sv
// fixed-point alu top level: multiply register, entry logic, divider cell chain, result stage
// Signed 32-bit fixed-point ALU with FRACTION_BITS fraction bits. busy is
// always low: one operation may be started every cycle. Every operation passes
// through the same 66 register stages (the multiply register, which feeds the
// entry logic, a chain of 64 division cells and one result register), so
// results leave in start order. The receiver cannot stall: each result is
// shown for one cycle with done_o high.
module fixed_point_alu #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fpa_pkg::fpa_in_t   in_i,
  output logic               done_o,
  output fpa_pkg::fpa_out_t  out_o
);
  import fpa_pkg::*;

  localparam int unsigned NCells = 64;
  localparam logic signed [31:0] ItofMax = 32'sh7fffffff >>> FRACTION_BITS;
  localparam logic signed [31:0] ItofMin = 32'sh80000000 >>> FRACTION_BITS;

  fpa_cell_t chain [NCells+1];
  fpa_cell_t ent_d;
  logic signed [63:0] a64, b64, sum64, prod_q, mshift;
  logic [63:0] dvd_mag;
  logic [31:0] dvs_mag;
  logic mul_vld_q;
  logic signed [31:0] mul_a_q, mul_b_q;
  logic [2:0] mul_op_q;
  fpa_out_t out_d, out_q;
  logic done_q;

  assign busy = 1'b0;

  // multiplier stage ahead of the chain so product is registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q  <= in_i.operand_a;
    mul_b_q  <= in_i.operand_b;
    mul_op_q <= in_i.opcode;
    prod_q   <= 64'(in_i.operand_a) * 64'(in_i.operand_b);
  end

  // entry: simple ops settle here, divide is set up for the chain
  always_comb begin
    a64     = 64'(mul_a_q);
    b64     = 64'(mul_b_q);
    sum64   = a64 + b64;
    mshift  = prod_q >>> FRACTION_BITS;
    dvd_mag = (mul_a_q[31] ? 64'(-a64) : 64'(a64)) << FRACTION_BITS;
    dvs_mag = mul_b_q[31] ? 32'(-mul_b_q) : 32'(mul_b_q);
    ent_d        = '0;
    ent_d.vld    = mul_vld_q;
    ent_d.opcode = mul_op_q;
    ent_d.rem    = dvd_mag;
    ent_d.dvs    = dvs_mag;
    ent_d.neg    = mul_a_q[31] ^ mul_b_q[31];
    case (mul_op_q)
      OP_ADD: begin
        if (sum64 != 64'(signed'(sum64[31:0]))) ent_d.ovf = 1'b1;
        else ent_d.res = sum64[31:0];
      end
      OP_SUB: ent_d.res = 32'(mul_a_q - mul_b_q);
      OP_MUL: begin
        if (mshift != 64'(signed'(mshift[31:0]))) ent_d.ovf = 1'b1;
        else ent_d.res = mshift[31:0];
      end
      OP_DIV: begin
        if (mul_b_q == '0) begin
          ent_d.dz     = 1'b1;
          ent_d.opcode = OP_ADD;
        end
      end
      OP_ITOF: begin
        if (mul_a_q > ItofMax || mul_a_q < ItofMin) ent_d.ovf = 1'b1;
        else ent_d.res = 32'(mul_a_q <<< FRACTION_BITS);
      end
      OP_FTOI: ent_d.res = 32'(mul_a_q >>> FRACTION_BITS);
      default: ent_d.res = '0;
    endcase
  end

  assign chain[0] = ent_d;

  // one cell per quotient bit, msb first
  for (genvar i = 0; i < NCells; i++) begin : g_cell
    fpa_cell #(.BitIdx(NCells - 1 - i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // final sign fix and range check for divide
  logic signed [63:0] q_signed;
  always_comb begin
    q_signed = chain[NCells].neg ? -$signed(chain[NCells].quo)
                                 : $signed(chain[NCells].quo);
    out_d.result         = chain[NCells].res;
    out_d.overflow       = chain[NCells].ovf;
    out_d.divide_by_zero = chain[NCells].dz;
    if (chain[NCells].opcode == OP_DIV) begin
      if (q_signed != 64'(signed'(q_signed[31:0]))) begin
        out_d.overflow = 1'b1;
        out_d.result   = '0;
      end else begin
        out_d.result = q_signed[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[NCells].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;
endmodule

>>> dv/tb_fixed_point_alu.sv
// testbench for the fixed-point alu: directed and random operations against a predictor
`timescale 1ns / 100ps

module tb_fixed_point_alu;
  import fpa_pkg::*;

  localparam int unsigned FRAC = 8;
  localparam int LATENCY = 67;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  fpa_in_t  in_i = '0;
  logic     done_o;
  fpa_out_t out_o;

  fpa_out_t expected_q[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       items_sent = 0;
  bit       failed = 0;

  fixed_point_alu #(.FRACTION_BITS(FRAC)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .done_o(done_o), .out_o(out_o)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // compute the result one operation should give
  function automatic fpa_out_t alu_predict(fpa_in_t it);
    fpa_out_t         o;
    logic signed [63:0] a, b, r, prod;
    logic signed [31:0] lo_lim, hi_lim;
    a = 64'(it.operand_a);
    b = 64'(it.operand_b);
    r = '0;
    o = '0;
    case (it.opcode)
      OP_ADD: r = a + b;
      OP_SUB: r = 64'(signed'(32'(it.operand_a - it.operand_b)));
      OP_MUL: begin
        prod = a * b;
        r = prod >>> FRAC;
      end
      OP_DIV: begin
        if (b == 0) o.divide_by_zero = 1'b1;
        else r = (a <<< FRAC) / b;
      end
      OP_ITOF: begin
        hi_lim = 32'sh7fffffff >>> FRAC;
        lo_lim = 32'sh80000000 >>> FRAC;
        if (it.operand_a > hi_lim || it.operand_a < lo_lim) o.overflow = 1'b1;
        else r = a <<< FRAC;
      end
      OP_FTOI: r = a >>> FRAC;
      default: r = '0;
    endcase
    if (r > 64'sh7fffffff || r < -64'sh80000000) begin
      r = '0;
      o.overflow = 1'b1;
    end
    o.result = r[31:0];
    return o;
  endfunction

  // send one operation, waiting for busy low
  task automatic send_op(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    fpa_in_t it;
    it.opcode = op;
    it.operand_a = a;
    it.operand_b = b;
    in_i <= it;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(alu_predict(it));
    items_sent++;
    @(negedge clk_i);
  endtask

  // idle gap after a transfer, mostly short, sometimes long
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
        ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // result check on every strobe
  always @(posedge clk_i) begin
    fpa_out_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_o);
      end else begin
        e = expected_q.pop_front();
        if (out_o.result !== e.result || out_o.overflow !== e.overflow ||
            out_o.divide_by_zero !== e.divide_by_zero) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected res=%h ovf=%b dz=%b got res=%h ovf=%b dz=%b",
                     e.result, e.overflow, e.divide_by_zero,
                     out_o.result, out_o.overflow, out_o.divide_by_zero);
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2047)) - 1024);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // field extremes and each operation's edge cases
  task automatic test_directed();
    send_op(OP_ADD, 32'h7fffffff, 32'h00000001);
    send_op(OP_ADD, 32'h80000000, 32'hffffffff);
    send_op(OP_ADD, 32'h00000100, 32'h00000200);
    send_op(OP_SUB, 32'h80000000, 32'h00000001);
    send_op(OP_SUB, 32'h7fffffff, 32'hffffffff);
    send_op(OP_MUL, 32'h7fffffff, 32'h7fffffff);
    send_op(OP_MUL, 32'hffffffff, 32'h00000001);
    send_op(OP_MUL, 32'h80000000, 32'h00000100);
    send_op(OP_MUL, 32'h00000300, 32'hfffffe00);
    send_op(OP_DIV, 32'h00000100, 32'h00000000);
    send_op(OP_DIV, 32'h80000000, 32'h00000000);
    send_op(OP_DIV, 32'h7fffffff, 32'h00000001);
    send_op(OP_DIV, 32'h80000000, 32'hffffffff);
    send_op(OP_DIV, 32'hffffff00, 32'h00000300);
    send_op(OP_DIV, 32'h00000001, 32'h80000000);
    send_op(OP_ITOF, 32'h007fffff, 32'hffffffff);
    send_op(OP_ITOF, 32'h00800000, 32'h0);
    send_op(OP_ITOF, 32'hff800000, 32'h0);
    send_op(OP_ITOF, 32'hff7fffff, 32'h0);
    send_op(OP_FTOI, 32'hffffffff, 32'h0);
    send_op(OP_FTOI, 32'h80000000, 32'h0);
    send_op(OP_FTOI, 32'h7fffffff, 32'h0);
    send_op(3'd6, 32'h12345678, 32'h9abcdef0);
    send_op(3'd7, 32'hffffffff, 32'hffffffff);
  endtask

  // random operations with random gaps
  task automatic test_random(int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_op(op, rand_operand(), ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand());
      if ($urandom_range(0, 99) < 70 || i % 200 > 150) begin
        if (i % 200 <= 150) idle_gap();
      end
    end
    start <= 1'b0;
  endtask

  // wait for every result to arrive, then let the pipeline drain
  task automatic test_drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1600);
    test_drain();
    $display("covered %0d operations, all opcodes incl. unused, overflow and divide by zero",
             items_sent);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (!failed && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
